[hdl/hcsd_pkg.sv]
// Package with types, constants and the quarter-round helper for the HChaCha subkey block.
package hcsd_pkg;

  localparam int NumStages = 40;
  localparam int AddrWidth = 6;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam logic [AddrWidth-1:0] ADDR_KEY_PART_0   = 6'd0;
  localparam logic [AddrWidth-1:0] ADDR_KEY_PART_1   = 6'd8;
  localparam logic [AddrWidth-1:0] ADDR_KEY_PART_2   = 6'd16;
  localparam logic [AddrWidth-1:0] ADDR_KEY_PART_3   = 6'd24;
  localparam logic [AddrWidth-1:0] ADDR_ROUND_COUNT  = 6'd32;

  localparam logic [4:0] ROUND_COUNT_RESET = 5'd20;

  typedef struct packed {
    logic [63:0] nonce_low;
    logic [63:0] nonce_high;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [63:0] subkey_part_0;
    logic [63:0] subkey_part_1;
    logic [63:0] subkey_part_2;
    logic [63:0] subkey_part_3;
  } out_word_t;

  typedef struct packed {
    logic              err;
    logic [15:0][31:0] w;
  } stage_t;

  typedef struct packed {
    logic [255:0] key;
    logic [4:0]   round_count;
  } cfg_t;

  // Word indices of the four quarter-rounds, column round then diagonal round.
  localparam logic [3:0][3:0][3:0] COL_IDX = '{
    '{4'd15, 4'd11, 4'd7, 4'd3},
    '{4'd14, 4'd10, 4'd6, 4'd2},
    '{4'd13, 4'd9,  4'd5, 4'd1},
    '{4'd12, 4'd8,  4'd4, 4'd0}
  };
  localparam logic [3:0][3:0][3:0] DIAG_IDX = '{
    '{4'd14, 4'd9,  4'd4, 4'd3},
    '{4'd13, 4'd8,  4'd7, 4'd2},
    '{4'd12, 4'd11, 4'd6, 4'd1},
    '{4'd15, 4'd10, 4'd5, 4'd0}
  };

  // One half of a quarter-round: two adds, two xors and two rotations.
  // The result holds a, b, c, d in lanes 0 to 3.
  function automatic logic [3:0][31:0] qr_half(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c, input logic [31:0] d,
                                               input logic second);
    logic [31:0] a1;
    logic [31:0] b1;
    logic [31:0] c1;
    logic [31:0] d1;
    logic [31:0] dx;
    logic [31:0] bx;
    logic [3:0][31:0] res;
    a1 = a + b;
    dx = d ^ a1;
    if (second) d1 = {dx[23:0], dx[31:24]};
    else        d1 = {dx[15:0], dx[31:16]};
    c1 = c + d1;
    bx = b ^ c1;
    if (second) b1 = {bx[24:0], bx[31:25]};
    else        b1 = {bx[19:0], bx[31:20]};
    res[0] = a1;
    res[1] = b1;
    res[2] = c1;
    res[3] = d1;
    return res;
  endfunction

endpackage

[hdl/hcsd_apb_regs.sv]
// Configuration registers of the HChaCha subkey block behind an APB-style port.
module hcsd_apb_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hcsd_pkg::AddrWidth-1:0] cfg_paddr,
  input  logic [63:0]                    cfg_pwdata,
  output logic [63:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output hcsd_pkg::cfg_t                 cfg
);
  import hcsd_pkg::*;

  logic [3:0][63:0] key_r;
  logic [4:0]       round_count_r;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r         <= '0;
      round_count_r <= ROUND_COUNT_RESET;
    end else if (wr_en) begin
      case (cfg_paddr)
        ADDR_KEY_PART_0:  key_r[0]      <= cfg_pwdata;
        ADDR_KEY_PART_1:  key_r[1]      <= cfg_pwdata;
        ADDR_KEY_PART_2:  key_r[2]      <= cfg_pwdata;
        ADDR_KEY_PART_3:  key_r[3]      <= cfg_pwdata;
        ADDR_ROUND_COUNT: round_count_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_KEY_PART_0:  cfg_prdata = key_r[0];
      ADDR_KEY_PART_1:  cfg_prdata = key_r[1];
      ADDR_KEY_PART_2:  cfg_prdata = key_r[2];
      ADDR_KEY_PART_3:  cfg_prdata = key_r[3];
      ADDR_ROUND_COUNT: cfg_prdata = {59'd0, round_count_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg.key         = key_r;
  assign cfg.round_count = round_count_r;

endmodule

[hdl/hcsd_round_stage.sv]
// One pipeline stage: half of each of the four quarter-rounds of a column or diagonal round.
module hcsd_round_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             diag,
  input  logic             second,
  input  logic             active,
  input  logic             in_valid,
  input  hcsd_pkg::stage_t in_data,
  output logic             out_valid_r,
  output hcsd_pkg::stage_t out_data_r
);
  import hcsd_pkg::*;

  stage_t           data_nxt;
  logic [3:0][31:0] qr_res [4];

  always_comb begin
    data_nxt = in_data;
    for (int q = 0; q < 4; q++) begin
      if (diag) begin
        qr_res[q] = qr_half(in_data.w[DIAG_IDX[q][0]], in_data.w[DIAG_IDX[q][1]],
                            in_data.w[DIAG_IDX[q][2]], in_data.w[DIAG_IDX[q][3]], second);
      end else begin
        qr_res[q] = qr_half(in_data.w[COL_IDX[q][0]], in_data.w[COL_IDX[q][1]],
                            in_data.w[COL_IDX[q][2]], in_data.w[COL_IDX[q][3]], second);
      end
      if (active) begin
        for (int p = 0; p < 4; p++) begin
          if (diag) data_nxt.w[DIAG_IDX[q][p]] = qr_res[q][p];
          else      data_nxt.w[COL_IDX[q][p]]  = qr_res[q][p];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= data_nxt;
    end
  end

endmodule

[hdl/hchacha_subkey_derive.sv]
// Top level of the HChaCha subkey derivation block.
//
// The key (four 64-bit parts) and the round count are to be set through the
// APB-style configuration port only while the block is idle; the block itself
// does not enforce this. Each input word carries a 128-bit nonce; each gives
// exactly one result word holding a status bit and the 256-bit subkey. A round
// count other than 8, 12 or 20 yields status 1 and a zero subkey.
// The rounds run in a 40-stage pipeline, two stages per round. Rounds beyond the
// configured count pass through unchanged, so latency does not depend on the
// round count. One word can be accepted every cycle while in_stall is low; the
// last stage doubles as the output register.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
// Reset clears all valid bits, the key to zero and the round count to 20.
module hchacha_subkey_derive (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hcsd_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hcsd_pkg::out_word_t            out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hcsd_pkg::AddrWidth-1:0] cfg_paddr,
  input  logic [63:0]                    cfg_pwdata,
  output logic [63:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import hcsd_pkg::*;

  cfg_t   cfg;
  logic   adv;
  logic   rc_bad;
  stage_t load;
  logic   valid_pipe [NumStages+1];
  stage_t data_pipe  [NumStages+1];

  hcsd_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign rc_bad = !(cfg.round_count == 5'd8 || cfg.round_count == 5'd12 ||
                    cfg.round_count == 5'd20);

  always_comb begin
    load.err   = rc_bad;
    load.w[0]  = SIGMA_0;
    load.w[1]  = SIGMA_1;
    load.w[2]  = SIGMA_2;
    load.w[3]  = SIGMA_3;
    for (int k = 0; k < 8; k++) begin
      load.w[4+k] = cfg.key[32*k +: 32];
    end
    load.w[12] = in_data.nonce_low[31:0];
    load.w[13] = in_data.nonce_low[63:32];
    load.w[14] = in_data.nonce_high[31:0];
    load.w[15] = in_data.nonce_high[63:32];
  end

  // The pipeline moves as one unless a finished result is held by the receiver.
  assign adv      = !(valid_pipe[NumStages] && out_stall);
  assign in_stall = !adv;

  assign valid_pipe[0] = in_valid;
  assign data_pipe[0]  = load;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    localparam logic [4:0] RoundIdx = 5'(s / 2);
    logic active;
    assign active = RoundIdx < cfg.round_count;
    hcsd_round_stage u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .adv         (adv),
      .diag        (RoundIdx[0]),
      .second      (1'(s % 2)),
      .active      (active),
      .in_valid    (valid_pipe[s]),
      .in_data     (data_pipe[s]),
      .out_valid_r (valid_pipe[s+1]),
      .out_data_r  (data_pipe[s+1])
    );
  end

  stage_t fin;
  assign fin       = data_pipe[NumStages];
  assign out_valid = valid_pipe[NumStages];

  always_comb begin
    out_data.status = fin.err;
    if (fin.err) begin
      out_data.subkey_part_0 = '0;
      out_data.subkey_part_1 = '0;
      out_data.subkey_part_2 = '0;
      out_data.subkey_part_3 = '0;
    end else begin
      out_data.subkey_part_0 = {fin.w[1], fin.w[0]};
      out_data.subkey_part_1 = {fin.w[3], fin.w[2]};
      out_data.subkey_part_2 = {fin.w[13], fin.w[12]};
      out_data.subkey_part_3 = {fin.w[15], fin.w[14]};
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.subkey_part_0 == '0 && out_data.subkey_part_3 == '0)
    else $error("error result carries a nonzero subkey");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) && rst_n |-> !out_valid)
    else $error("result valid right after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> valid_pipe[1] == $past(valid_pipe[1]))
    else $error("pipeline moved while the result was held");

  a_rc_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_ROUND_COUNT |=>
      cfg.round_count == $past(cfg_pwdata[4:0]))
    else $error("round count write lost");
`endif

endmodule

[test/testbench.sv]
// Self-checking testbench for the HChaCha subkey derivation block.
`timescale 1ns / 1ps

module testbench;
  import hcsd_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [AddrWidth-1:0] cfg_paddr = '0;
  logic [63:0]          cfg_pwdata = '0;
  logic [63:0]          cfg_prdata;
  logic                 cfg_pready;

  hchacha_subkey_derive u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the key and round count.
  logic [63:0] key_shadow [4];
  logic [4:0]  rounds_shadow = ROUND_COUNT_RESET;

  out_word_t subkey_queue [$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_off_cycles = 0;
  int        errors = 0;
  int        cycles = 0;

  function automatic logic [31:0] rotl32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter(ref logic [31:0] s [16], input int a, int b, int c, int d);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 16);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 12);
    s[a] = s[a] + s[b]; s[d] = rotl32(s[d] ^ s[a], 8);
    s[c] = s[c] + s[d]; s[b] = rotl32(s[b] ^ s[c], 7);
  endfunction

  function automatic out_word_t derive_subkey(in_word_t nonce);
    logic [31:0] s [16];
    out_word_t   res;
    res = '0;
    if (rounds_shadow != 5'd8 && rounds_shadow != 5'd12 && rounds_shadow != 5'd20) begin
      res.status = 1'b1;
      return res;
    end
    s[0] = SIGMA_0; s[1] = SIGMA_1; s[2] = SIGMA_2; s[3] = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      s[4 + 2 * k] = key_shadow[k][31:0];
      s[5 + 2 * k] = key_shadow[k][63:32];
    end
    s[12] = nonce.nonce_low[31:0];  s[13] = nonce.nonce_low[63:32];
    s[14] = nonce.nonce_high[31:0]; s[15] = nonce.nonce_high[63:32];
    for (int r = 0; r < rounds_shadow; r += 2) begin
      quarter(s, 0, 4, 8, 12);  quarter(s, 1, 5, 9, 13);
      quarter(s, 2, 6, 10, 14); quarter(s, 3, 7, 11, 15);
      quarter(s, 0, 5, 10, 15); quarter(s, 1, 6, 11, 12);
      quarter(s, 2, 7, 8, 13);  quarter(s, 3, 4, 9, 14);
    end
    res.subkey_part_0 = {s[1], s[0]};
    res.subkey_part_1 = {s[3], s[2]};
    res.subkey_part_2 = {s[13], s[12]};
    res.subkey_part_3 = {s[15], s[14]};
    return res;
  endfunction

  // The word stays offered after acceptance until the next word or a drain replaces it,
  // so back-to-back words need no gap.
  task automatic send_nonce(in_word_t nonce);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= nonce;
    subkey_queue.push_back(derive_subkey(nonce));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [AddrWidth-1:0] addr, logic [63:0] value);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (addr)
      ADDR_KEY_PART_0:  key_shadow[0] = value;
      ADDR_KEY_PART_1:  key_shadow[1] = value;
      ADDR_KEY_PART_2:  key_shadow[2] = value;
      ADDR_KEY_PART_3:  key_shadow[3] = value;
      ADDR_ROUND_COUNT: rounds_shadow = value[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (subkey_queue.size() != 0) @(posedge clk);
    repeat (NumStages + 5) @(posedge clk);
  endtask

  task automatic set_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    write_reg(ADDR_KEY_PART_0, k0);
    write_reg(ADDR_KEY_PART_1, k1);
    write_reg(ADDR_KEY_PART_2, k2);
    write_reg(ADDR_KEY_PART_3, k3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(3))
      0: return 64'd0;
      1: return '1;
      2: return rand64();
      default: return 64'd1 << $urandom_range(63);
    endcase
  endfunction

  task automatic test_directed();
    in_word_t n;
    // Reset key with the default twenty rounds.
    n = '0;
    send_nonce(n);
    n = '1;
    send_nonce(n);
    wait_drained();
    set_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
            64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    n.nonce_low = 64'h4a00000009000000;
    n.nonce_high = 64'h2741593100000000;
    send_nonce(n);
    n.nonce_low = 64'h8000000000000001;
    n.nonce_high = 64'h0000000180000000;
    send_nonce(n);
    wait_drained();
    set_key('1, '1, '1, '1);
    for (int rc = 0; rc < 32; rc += 4) begin
      wait_drained();
      write_reg(ADDR_ROUND_COUNT, {59'h5a5a5a5a5a5a5a5, rc[4:0]});
      n = '1;
      send_nonce(n);
      if (rc == 8) begin
        wait_drained();
        write_reg(ADDR_ROUND_COUNT, 64'd31);
      end
    end
    wait_drained();
    write_reg(ADDR_ROUND_COUNT, 64'd31);
    send_nonce({rand64(), rand64()});
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [4:0] rc;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        wait_drained();
        set_key(edge64(), edge64(), edge64(), edge64());
        case ($urandom_range(9))
          0: rc = 5'($urandom_range(31));
          1, 2, 3: rc = 5'd8;
          4, 5, 6: rc = 5'd12;
          default: rc = 5'd20;
        endcase
        write_reg(ADDR_ROUND_COUNT, {rand64()} & ~64'h1f | rc);
      end
      send_nonce({edge64(), edge64()});
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 300;
    for (int i = 0; i < 120; i++) send_nonce({rand64(), rand64()});
    wait_drained();
  endtask

  initial begin
    for (int k = 0; k < 4; k++) key_shadow[k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 34; recv_idle_pct = 69;
    test_random(450);
    send_idle_pct = 69; recv_idle_pct = 34;
    test_random(450);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(350);
    test_backpressure();
    wait_drained();
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (subkey_queue.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        out_word_t exp;
        exp = subkey_queue.pop_front();
        if (exp.status !== out_data.status)
          $display("%0t: status expected %h actual %h", $time, exp.status, out_data.status);
        if (exp.subkey_part_0 !== out_data.subkey_part_0)
          $display("%0t: subkey_part_0 expected %h actual %h", $time,
                   exp.subkey_part_0, out_data.subkey_part_0);
        if (exp.subkey_part_1 !== out_data.subkey_part_1)
          $display("%0t: subkey_part_1 expected %h actual %h", $time,
                   exp.subkey_part_1, out_data.subkey_part_1);
        if (exp.subkey_part_2 !== out_data.subkey_part_2)
          $display("%0t: subkey_part_2 expected %h actual %h", $time,
                   exp.subkey_part_2, out_data.subkey_part_2);
        if (exp.subkey_part_3 !== out_data.subkey_part_3)
          $display("%0t: subkey_part_3 expected %h actual %h", $time,
                   exp.subkey_part_3, out_data.subkey_part_3);
        if (exp !== out_data) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 1000000) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule
